[rtl/core/uuencode_line_encoder_defines.svh]
// ----------------------------------------------------------------------------
// uuencode line encoder assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef UUENCODE_LINE_ENCODER_DEFINES_SVH
`define UUENCODE_LINE_ENCODER_DEFINES_SVH

// same-cycle implication
`define UULE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define UULE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/core/uule_pkg.sv]
// ----------------------------------------------------------------------------
// uule_pkg
// Types, constants and the character coder of the uuencode line encoder.
// ----------------------------------------------------------------------------
package uule_pkg;

   localparam int LINE_BYTES_DEFAULT = 45;

   localparam logic [6:0] NEWLINE_CHAR = 7'd10;
   localparam logic [6:0] ZERO_CHAR    = 7'd96;
   localparam logic [6:0] CHAR_OFFSET  = 7'd32;

   // output character source
   localparam logic [1:0] SEL_LEN  = 2'd0;
   localparam logic [1:0] SEL_DATA = 2'd1;
   localparam logic [1:0] SEL_NL   = 2'd2;
   localparam logic [1:0] SEL_ZERO = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_file;
   } req_word_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic       write_byte;
      logic       clear_count;
      logic       start_line;
      logic       capture;
      logic       push;
      logic [1:0] sel;
      logic [1:0] ch;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic will_fill;
      logic empty;
      logic line_done;
      logic can_push;
   } status_type;

   function automatic logic [6:0] enc6(input logic [5:0] v);
      logic [6:0] c;
      if (v == 6'd0) begin
         c = ZERO_CHAR;
      end else begin
         c = {1'b0, v} + CHAR_OFFSET;
      end
      return c;
   endfunction

endpackage

[rtl/core/uule_datapath.sv]
// ----------------------------------------------------------------------------
// uule_datapath
// Line buffer, byte count, group register and registered output word.
// ----------------------------------------------------------------------------
module uule_datapath #(
   parameter int LINE_BYTES = uule_pkg::LINE_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  uule_pkg::req_word_type req_word,
   input  uule_pkg::cmd_type     cmd,
   output uule_pkg::status_type  status,
   output logic                  rsp_valid,
   output uule_pkg::rsp_word_type rsp_word,
   input  logic                  rsp_stall
);

   localparam int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
   localparam int CW = $clog2(LINE_BYTES + 1);
   localparam int IW = $clog2(LINE_BYTES + 3);

   logic [7:0]    line_mem [LINE_BYTES];
   logic [7:0]    rd_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [23:0]   grp_ff, grp_in;
   logic [7:0]    cap_byte;
   logic [5:0]    data_val;
   logic [6:0]    char_val;
   logic          rsp_valid_ff, rsp_valid_in;
   uule_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   always_ff @(posedge clock) begin
      if (cmd.write_byte) begin
         line_mem[count_ff[AW-1:0]] <= req_word.data_byte;
      end
      rd_ff <= line_mem[idx_ff[AW-1:0]];
   end

   // bytes past the line end read as zero
   assign cap_byte = (idx_ff < IW'(count_ff)) ? rd_ff : 8'd0;

   always_comb begin
      count_in = count_ff;
      if (cmd.clear_count) begin
         count_in = '0;
      end else if (cmd.write_byte) begin
         count_in = count_ff + CW'(1);
      end
      idx_in = idx_ff;
      grp_in = grp_ff;
      if (cmd.start_line) begin
         idx_in = '0;
      end else if (cmd.capture) begin
         idx_in = idx_ff + IW'(1);
         grp_in = {grp_ff[15:0], cap_byte};
      end
   end

   always_comb begin
      case (cmd.ch)
         2'd0:    data_val = grp_ff[23:18];
         2'd1:    data_val = grp_ff[17:12];
         2'd2:    data_val = grp_ff[11:6];
         default: data_val = grp_ff[5:0];
      endcase
      case (cmd.sel)
         uule_pkg::SEL_LEN:  char_val = uule_pkg::enc6(6'(count_ff));
         uule_pkg::SEL_DATA: char_val = uule_pkg::enc6(data_val);
         uule_pkg::SEL_NL:   char_val = uule_pkg::NEWLINE_CHAR;
         default:            char_val = uule_pkg::ZERO_CHAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (cmd.push) begin
         rsp_valid_in         = 1'b1;
         rsp_word_in.out_char = char_val;
         rsp_word_in.last_of_run = cmd.last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      grp_ff      <= grp_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign status.will_fill = (count_ff == CW'(LINE_BYTES - 1));
   assign status.empty     = (count_ff == '0);
   assign status.line_done = (idx_ff >= IW'(count_ff));
   assign status.can_push  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[rtl/core/uule_ctrl.sv]
// ----------------------------------------------------------------------------
// uule_ctrl
// Sequencer: accepts words, walks a line group by group, closes the stream.
// ----------------------------------------------------------------------------
module uule_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  uule_pkg::req_word_type req_word,
   output logic                   req_stall,
   input  uule_pkg::status_type   status,
   output uule_pkg::cmd_type      cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LEN  = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_CAP  = 3'd3;
   localparam logic [2:0] S_CH   = 3'd4;
   localparam logic [2:0] S_NL   = 3'd5;
   localparam logic [2:0] S_CL0  = 3'd6;
   localparam logic [2:0] S_CL1  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       eof_ff, eof_in;
   logic [1:0] bc_ff, bc_in;
   logic [1:0] ch_ff, ch_in;

   always_comb begin
      state_in  = state_ff;
      eof_in    = eof_ff;
      bc_in     = bc_ff;
      ch_in     = ch_ff;
      req_stall = 1'b1;
      cmd       = '0;
      cmd.sel   = uule_pkg::SEL_LEN;
      cmd.ch    = ch_ff;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.write_byte = req_word.has_byte;
               eof_in         = req_word.end_of_file;
               if (req_word.has_byte && status.will_fill) begin
                  state_in = S_LEN;
               end else if (req_word.end_of_file) begin
                  state_in = (req_word.has_byte || !status.empty) ? S_LEN : S_CL0;
               end
            end
         end
         S_LEN: begin
            cmd.sel = uule_pkg::SEL_LEN;
            if (status.can_push) begin
               cmd.push       = 1'b1;
               cmd.start_line = 1'b1;
               bc_in          = 2'd0;
               state_in       = S_RD;
            end
         end
         S_RD: begin
            state_in = S_CAP;
         end
         S_CAP: begin
            cmd.capture = 1'b1;
            bc_in       = bc_ff + 2'd1;
            if (bc_ff == 2'd2) begin
               ch_in    = 2'd0;
               state_in = S_CH;
            end else begin
               state_in = S_RD;
            end
         end
         S_CH: begin
            cmd.sel = uule_pkg::SEL_DATA;
            if (status.can_push) begin
               cmd.push = 1'b1;
               ch_in    = ch_ff + 2'd1;
               if (ch_ff == 2'd3) begin
                  bc_in    = 2'd0;
                  state_in = status.line_done ? S_NL : S_RD;
               end
            end
         end
         S_NL: begin
            cmd.sel = uule_pkg::SEL_NL;
            if (status.can_push) begin
               cmd.push        = 1'b1;
               cmd.clear_count = 1'b1;
               cmd.last        = !eof_ff;
               state_in        = eof_ff ? S_CL0 : S_IDLE;
            end
         end
         S_CL0: begin
            cmd.sel = uule_pkg::SEL_ZERO;
            if (status.can_push) begin
               cmd.push = 1'b1;
               state_in = S_CL1;
            end
         end
         S_CL1: begin
            cmd.sel = uule_pkg::SEL_NL;
            if (status.can_push) begin
               cmd.push = 1'b1;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         eof_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         eof_ff   <= eof_in;
      end
      bc_ff <= bc_in;
      ch_ff <= ch_in;
   end

endmodule

[rtl/core/uuencode_line_encoder.sv]
// ----------------------------------------------------------------------------
// uuencode_line_encoder
// Byte stream to uuencoded text lines, one character per output word.
// ----------------------------------------------------------------------------
// Input words carry a byte (has_byte) and/or an end-of-file mark. A byte that
// does not complete a line is stored and gives no output.
// When LINE_BYTES bytes are buffered, or at end of file with bytes pending,
// a line goes out: length char, 4 chars per 3-byte group, newline. End of
// file then adds the closing line of a zero char and a newline.
// Input stalls while a line is being sent. Per group the sequencer fetches
// three bytes from the line buffer, one read and one capture per byte, then
// sends 4 chars, each waiting while rsp_stall holds a waiting word. The
// first char is pushed from S_LEN into the output register.
// Output passes through one register; a stall on rsp holds the word and
// the sequencer waits before its next push, nothing is dropped. last_of_run
// marks the final char caused by an input word.
// Reset clears the byte count and sequencer; the line buffer is not cleared.
// ----------------------------------------------------------------------------
`include "uuencode_line_encoder_defines.svh"

module uuencode_line_encoder #(
   parameter int LINE_BYTES = uule_pkg::LINE_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  uule_pkg::req_word_type req_word,
   output logic                   req_stall,
   output logic                   rsp_valid,
   output uule_pkg::rsp_word_type rsp_word,
   input  logic                   rsp_stall
);

   uule_pkg::cmd_type    cmd;
   uule_pkg::status_type status;

   uule_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_word  (req_word),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   uule_datapath #(
      .LINE_BYTES (LINE_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_stall (rsp_stall)
   );

   `UULE_ASSERT_SAME(a_push_room, clock, reset, cmd.push, status.can_push)
   `UULE_ASSERT_SAME(a_last_is_newline, clock, reset, rsp_valid && rsp_word.last_of_run, rsp_word.out_char == uule_pkg::NEWLINE_CHAR)
   `UULE_ASSERT_NEXT(a_eof_busy, clock, reset, req_valid && !req_stall && req_word.end_of_file, req_stall)

endmodule
